@@ rtl/rfc8_pkg.sv @@
// shared types, constants and the crc-8 step for the response framer
package rfc8_pkg;

  localparam int MAX_FRAME   = 11;
  localparam int LEN_W       = $clog2(MAX_FRAME - 1);
  localparam int PLD_KEEP    = 5;
  localparam int PLD_IDX_W   = $clog2(PLD_KEEP);
  localparam int SET_MIN_LEN  = 5;
  localparam int FREQ_MIN_LEN = 3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] PRE1_BYTE = 8'hAA;
  localparam logic [7:0] PRE2_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_FRAME - 2);

  localparam logic [7:0] CODE_SETTINGS_V1 = 8'h01;
  localparam logic [7:0] CODE_SET_POWER   = 8'h02;
  localparam logic [7:0] CODE_SET_CHANNEL = 8'h03;
  localparam logic [7:0] CODE_SET_FREQ    = 8'h04;
  localparam logic [7:0] CODE_SET_MODE    = 8'h05;
  localparam logic [7:0] CODE_SETTINGS_V2 = 8'h09;

  localparam logic [1:0]  VERSION_1     = 2'd1;
  localparam logic [1:0]  VERSION_2     = 2'd2;
  localparam logic [15:0] FREQ_PIT_MASK = 16'hC000;

  typedef enum logic [2:0] {
    PH_PRE1 = 3'd0,
    PH_PRE2 = 3'd1,
    PH_CODE = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRC  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_OK      = 3'd0,
    EV_BADCODE = 3'd1,
    EV_BADPRE  = 3'd2,
    EV_BADLEN  = 3'd3,
    EV_ECHO    = 3'd4,
    EV_CRC     = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    UPD_NONE     = 2'd0,
    UPD_SETTINGS = 2'd1,
    UPD_FREQ     = 2'd2
  } upd_t;

  typedef struct packed {
    event_t                     ev;
    logic [7:0]                 code;
    upd_t                       upd;
    logic [PLD_KEEP-1:0][7:0]   pld;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [1:0]  version;
    logic [7:0]  channel;
    logic [7:0]  power;
    logic [7:0]  mode;
    logic [15:0] freq;
    logic [13:0] pit_freq;
  } dev_rec_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [13:0] pit_freq;
    logic [15:0] freq;
    logic [7:0]  mode;
    logic [7:0]  power;
    logic [7:0]  channel;
    logic [1:0]  version;
    logic [7:0]  code;
    logic [2:0]  ev;
  } out_word_t;

  localparam int OUT_W = $bits(out_word_t);

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

@@ rtl/response_framer_crc8_core.sv @@
// top level of the crc-8 response framer
// One received byte is taken per transaction on the in_ stream, one per cycle
// while the two-entry job queue has room; the byte is framed and crc-checked
// in the cycle it is accepted. Each frame end or framing error yields one
// result transaction, which passes through the queue and then the output
// register. Results leave at one per cycle while out_tready is held high.
// The result carries the event, the response code and the device record as
// it stands after that frame. Bytes that close no frame produce no result.
module response_framer_crc8_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // event_res[2:0], resp_code[10:3], dev_version[12:11], dev_channel[20:13],
  // dev_power[28:21], dev_mode[36:29], dev_freq[52:37], dev_pit_freq[66:53], zero pad
  output logic [rfc8_pkg::OUT_W-1:0] out_tdata
);

  rfc8_pkg::fifo_stat_t fifo_stat;
  rfc8_pkg::job_t       push_job;
  rfc8_pkg::job_t       pop_job;
  logic                 push;
  logic                 pop;

  rfc8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .job       (push_job)
  );

  rfc8_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_job),
    .pop     (pop),
    .rd_data (pop_job),
    .stat    (fifo_stat)
  );

  rfc8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .job        (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/rfc8_front.sv @@
// framer front end: preamble hunt, crc check and frame classification
module rfc8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // rx_byte[7:0]
  input  rfc8_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output rfc8_pkg::job_t      job
);

  rfc8_pkg::phase_t             phase_r, phase_nxt;
  logic [rfc8_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [rfc8_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]                   crc_r, crc_nxt;
  logic [7:0]                   code_r, code_nxt;
  logic [rfc8_pkg::PLD_KEEP-1:0][7:0] pld_r, pld_nxt;
  logic                         acc;
  logic [7:0]                   c;
  logic [rfc8_pkg::LEN_W-1:0]   cnt_inc;

  assign in_tready = !fifo_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign cnt_inc   = cnt_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        rfc8_pkg::PH_PRE2: begin
          phase_nxt = (c == rfc8_pkg::PRE2_BYTE) ? rfc8_pkg::PH_CODE : rfc8_pkg::PH_PRE1;
        end
        rfc8_pkg::PH_CODE: begin
          phase_nxt = rfc8_pkg::PH_LEN;
        end
        rfc8_pkg::PH_LEN: begin
          if (c > rfc8_pkg::LEN_LIMIT) begin
            phase_nxt = rfc8_pkg::PH_PRE1;
          end else if (c == 8'd0) begin
            phase_nxt = rfc8_pkg::PH_CRC;
          end else begin
            phase_nxt = rfc8_pkg::PH_DATA;
          end
        end
        rfc8_pkg::PH_DATA: begin
          phase_nxt = (cnt_inc >= len_r) ? rfc8_pkg::PH_CRC : rfc8_pkg::PH_DATA;
        end
        rfc8_pkg::PH_CRC: begin
          phase_nxt = rfc8_pkg::PH_PRE1;
        end
        default: begin
          phase_nxt = (c == rfc8_pkg::PRE1_BYTE) ? rfc8_pkg::PH_PRE2 : rfc8_pkg::PH_PRE1;
        end
      endcase
    end
  end

  always_comb begin
    push     = 1'b0;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    code_nxt = code_r;
    pld_nxt  = pld_r;
    job.ev   = rfc8_pkg::EV_OK;
    job.code = code_r;
    job.upd  = rfc8_pkg::UPD_NONE;
    job.pld  = pld_r;
    if (acc) begin
      unique case (phase_r)
        rfc8_pkg::PH_PRE2: begin
          if (c != rfc8_pkg::PRE2_BYTE) begin
            push     = 1'b1;
            job.ev   = rfc8_pkg::EV_BADPRE;
            job.code = 8'd0;
          end
        end
        rfc8_pkg::PH_CODE: begin
          code_nxt = c;
          crc_nxt  = rfc8_pkg::crc8_step(8'd0, c);
        end
        rfc8_pkg::PH_LEN: begin
          if (c > rfc8_pkg::LEN_LIMIT) begin
            push   = 1'b1;
            job.ev = rfc8_pkg::EV_BADLEN;
          end else begin
            len_nxt = c[rfc8_pkg::LEN_W-1:0];
            cnt_nxt = '0;
            crc_nxt = rfc8_pkg::crc8_step(crc_r, c);
          end
        end
        rfc8_pkg::PH_DATA: begin
          if (cnt_r < rfc8_pkg::LEN_W'(rfc8_pkg::PLD_KEEP)) begin
            pld_nxt[cnt_r[rfc8_pkg::PLD_IDX_W-1:0]] = c;
          end
          crc_nxt = rfc8_pkg::crc8_step(crc_r, c);
          cnt_nxt = cnt_inc;
        end
        rfc8_pkg::PH_CRC: begin
          push = 1'b1;
          if (crc_r == c) begin
            case (code_r)
              rfc8_pkg::CODE_SETTINGS_V1, rfc8_pkg::CODE_SETTINGS_V2: begin
                if (len_r >= rfc8_pkg::LEN_W'(rfc8_pkg::SET_MIN_LEN)) begin
                  job.upd = rfc8_pkg::UPD_SETTINGS;
                end
              end
              rfc8_pkg::CODE_SET_FREQ: begin
                if (len_r >= rfc8_pkg::LEN_W'(rfc8_pkg::FREQ_MIN_LEN)) begin
                  job.upd = rfc8_pkg::UPD_FREQ;
                end
              end
              rfc8_pkg::CODE_SET_POWER, rfc8_pkg::CODE_SET_CHANNEL,
              rfc8_pkg::CODE_SET_MODE: begin
                job.ev = rfc8_pkg::EV_OK;
              end
              default: begin
                job.ev = rfc8_pkg::EV_BADCODE;
              end
            endcase
          end else if (code_r[0]) begin
            job.ev = rfc8_pkg::EV_ECHO;
          end else begin
            job.ev = rfc8_pkg::EV_CRC;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfc8_pkg::PH_PRE1;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    pld_r  <= pld_nxt;
  end

`ifndef NO_ASSERTIONS
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_tvalid && in_tready))
    else $error("job pushed without an accepted byte");

  a_push_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (phase_r == rfc8_pkg::PH_PRE1))
    else $error("framer did not return to hunt after a frame event");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rfc8_pkg::PH_DATA) |-> (cnt_r < len_r))
    else $error("payload count reached length while still in payload");
`endif

endmodule

@@ rtl/rfc8_fifo.sv @@
// short job queue between the framer and the record update
module rfc8_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rfc8_pkg::job_t       wr_data,
  input  logic                 pop,
  output rfc8_pkg::job_t       rd_data,
  output rfc8_pkg::fifo_stat_t stat
);

  rfc8_pkg::job_t                  mem_r [rfc8_pkg::FIFO_DEPTH];
  logic [rfc8_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rfc8_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rfc8_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [rfc8_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    rfc8_pkg::FIFO_PTR_W'(rfc8_pkg::FIFO_DEPTH - 1);

  assign stat.full  = (cnt_r == rfc8_pkg::FIFO_CNT_W'(rfc8_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("job queue overflow");
`endif

endmodule

@@ rtl/rfc8_back.sv @@
// back end: device record update and registered result output
module rfc8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfc8_pkg::fifo_stat_t fifo_stat,
  input  rfc8_pkg::job_t       job,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [rfc8_pkg::OUT_W-1:0] out_tdata
);

  rfc8_pkg::dev_rec_t rec_r, rec_nxt;
  logic               out_valid_r, out_valid_nxt;
  rfc8_pkg::event_t   ev_r;
  logic [7:0]         code_r;
  logic [15:0]        f;
  rfc8_pkg::out_word_t word;

  assign pop = !fifo_stat.empty && (!out_valid_r || out_tready);
  assign f   = {job.pld[0], job.pld[1]};

  always_comb begin
    rec_nxt = rec_r;
    if (pop) begin
      case (job.upd)
        rfc8_pkg::UPD_SETTINGS: begin
          rec_nxt.version = (job.code == rfc8_pkg::CODE_SETTINGS_V1) ?
                            rfc8_pkg::VERSION_1 : rfc8_pkg::VERSION_2;
          rec_nxt.channel = job.pld[0];
          rec_nxt.power   = job.pld[1];
          rec_nxt.mode    = job.pld[2];
          rec_nxt.freq    = {job.pld[3], job.pld[4]};
        end
        rfc8_pkg::UPD_FREQ: begin
          if ((f & rfc8_pkg::FREQ_PIT_MASK) != 16'd0) begin
            rec_nxt.pit_freq = f[13:0];
          end else begin
            rec_nxt.freq = f;
          end
        end
        default: begin
          rec_nxt = rec_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      rec_r.version    <= 2'd0;
      rec_r.channel    <= 8'hFF;
      rec_r.power      <= 8'hFF;
      rec_r.mode       <= 8'd0;
      rec_r.freq       <= 16'd0;
      rec_r.pit_freq   <= 14'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rec_r       <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r   <= job.ev;
      code_r <= job.code;
    end
  end

  always_comb begin
    word.pad      = '0;
    word.pit_freq = rec_r.pit_freq;
    word.freq     = rec_r.freq;
    word.mode     = rec_r.mode;
    word.power    = rec_r.power;
    word.channel  = rec_r.channel;
    word.version  = rec_r.version;
    word.code     = code_r;
    word.ev       = ev_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = word;

`ifndef NO_ASSERTIONS
  a_version_legal: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r.version != 2'd3)
    else $error("device version took an unused value");
`endif

endmodule
